// ===== rtl/mmtm_pkg.sv =====
// Shared types, operation codes and arithmetic constants of the motion magnitude tone mapper.
package mmtm_pkg;

  localparam int AXIS_W     = 16;
  localparam int TONE_W     = 10;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int AXIS_COUNT     = 6;
  localparam int AXES_PER_GROUP = 3;

  // Divide by 100: multiply by ceil(2^19 / 100), keep bits above 19.
  localparam logic [12:0] AXIS_RECIP = 13'd5243;
  localparam int          AXIS_SHIFT = 19;
  // Divide by 1500: multiply by ceil(2^31 / 1500), keep bits above 31.
  localparam logic [20:0] TONE_RECIP = 21'd1431656;
  localparam int          TONE_SHIFT = 31;
  // Divide by 1000: multiply by ceil(2^30 / 1000), keep bits above 30.
  localparam logic [20:0] MIX_RECIP  = 21'd1073742;
  localparam int          MIX_SHIFT  = 30;

  localparam logic [TONE_W-1:0] WEIGHT_FULL  = 10'd1000;
  localparam logic [TONE_W-1:0] TONE_RESET   = 10'd20;
  localparam logic [TONE_W-1:0] MIN_RESET    = 10'd20;
  localparam logic [TONE_W-1:0] MAX_RESET    = 10'd300;
  localparam logic [TONE_W-1:0] WEIGHT_RESET = 10'd200;

  // Highest power of four that the root loop starts from.
  localparam logic [18:0] ROOT_TOP = 19'h40000;

  typedef logic [3:0] op_t;

  localparam op_t OP_LOAD    = 4'd0;
  localparam op_t OP_DIVAX   = 4'd1;
  localparam op_t OP_SQAX    = 4'd2;
  localparam op_t OP_ACCUM   = 4'd3;
  localparam op_t OP_SQINIT  = 4'd4;
  localparam op_t OP_SQSTEP  = 4'd5;
  localparam op_t OP_MAGADD  = 4'd6;
  localparam op_t OP_SQSUM   = 4'd7;
  localparam op_t OP_DIVTONE = 4'd8;
  localparam op_t OP_CLAMP   = 4'd9;
  localparam op_t OP_MULNEW  = 4'd10;
  localparam op_t OP_MULOLD  = 4'd11;
  localparam op_t OP_MIXADD  = 4'd12;
  localparam op_t OP_DIVMIX  = 4'd13;
  localparam op_t OP_EMIT    = 4'd14;

  typedef struct packed {
    op_t  op;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic axis_more;
    logic root_more;
    logic group_more;
  } stat_t;

endpackage

// ===== rtl/mmtm_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
module mmtm_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_valid,
  input  logic            out_ready,
  input  mmtm_pkg::stat_t stat,
  output mmtm_pkg::ctrl_t ctrl,
  output logic            in_ready
);
  import mmtm_pkg::*;

  typedef logic [2:0] cond_t;
  typedef logic [3:0] step_t;

  localparam cond_t JC_NEXT     = 3'd0;
  localparam cond_t JC_WAIT_IN  = 3'd1;
  localparam cond_t JC_AXIS     = 3'd2;
  localparam cond_t JC_ROOT     = 3'd3;
  localparam cond_t JC_GROUP    = 3'd4;
  localparam cond_t JC_WAIT_OUT = 3'd5;

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_AXIS = 4'd1;
  localparam step_t ST_ROOT = 4'd5;
  localparam step_t ST_EMIT = 4'd14;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  wrap;
  } cw_t;

  function automatic cw_t rom(input step_t step);
    cw_t cw;
    unique case (step)
      4'd0:    cw = '{OP_LOAD,    JC_WAIT_IN,  ST_IDLE, 1'b0};
      4'd1:    cw = '{OP_DIVAX,   JC_NEXT,     ST_IDLE, 1'b0};
      4'd2:    cw = '{OP_SQAX,    JC_NEXT,     ST_IDLE, 1'b0};
      4'd3:    cw = '{OP_ACCUM,   JC_AXIS,     ST_AXIS, 1'b0};
      4'd4:    cw = '{OP_SQINIT,  JC_NEXT,     ST_IDLE, 1'b0};
      4'd5:    cw = '{OP_SQSTEP,  JC_ROOT,     ST_ROOT, 1'b0};
      4'd6:    cw = '{OP_MAGADD,  JC_GROUP,    ST_AXIS, 1'b0};
      4'd7:    cw = '{OP_SQSUM,   JC_NEXT,     ST_IDLE, 1'b0};
      4'd8:    cw = '{OP_DIVTONE, JC_NEXT,     ST_IDLE, 1'b0};
      4'd9:    cw = '{OP_CLAMP,   JC_NEXT,     ST_IDLE, 1'b0};
      4'd10:   cw = '{OP_MULNEW,  JC_NEXT,     ST_IDLE, 1'b0};
      4'd11:   cw = '{OP_MULOLD,  JC_NEXT,     ST_IDLE, 1'b0};
      4'd12:   cw = '{OP_MIXADD,  JC_NEXT,     ST_IDLE, 1'b0};
      4'd13:   cw = '{OP_DIVMIX,  JC_NEXT,     ST_IDLE, 1'b0};
      4'd14:   cw = '{OP_EMIT,    JC_WAIT_OUT, ST_EMIT, 1'b1};
      default: cw = '{OP_LOAD,    JC_WAIT_IN,  ST_IDLE, 1'b0};
    endcase
    return cw;
  endfunction

  step_t pc;
  step_t pc_next;
  cw_t   cw;
  logic  hit;
  logic  waiting;

  assign cw = rom(pc);

  always_comb begin
    case (cw.cond)
      JC_WAIT_IN:  hit = !in_valid;
      JC_AXIS:     hit = stat.axis_more;
      JC_ROOT:     hit = stat.root_more;
      JC_GROUP:    hit = stat.group_more;
      JC_WAIT_OUT: hit = out_valid && !out_ready;
      default:     hit = 1'b0;
    endcase
  end

  // A wait step that hits holds its step and suppresses its action.
  assign waiting = (cw.cond == JC_WAIT_IN || cw.cond == JC_WAIT_OUT) && hit;

  always_comb begin
    if (hit) begin
      pc_next = cw.target;
    end else if (cw.wrap) begin
      pc_next = ST_IDLE;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.op  = cw.op;
  assign ctrl.go  = !waiting;
  assign in_ready = (cw.op == OP_LOAD);

endmodule

// ===== rtl/mmtm_datapath.sv =====
// Datapath: sample registers, shared multiplier, root unit, clamp and smoothing registers.
module mmtm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  mmtm_pkg::ctrl_t                     ctrl,
  output mmtm_pkg::stat_t                     stat,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]  accel_x,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]  accel_y,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]  accel_z,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]  gyro_x,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]  gyro_y,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]  gyro_z,
  input  logic        [mmtm_pkg::TONE_W-1:0]  min_tone,
  input  logic        [mmtm_pkg::TONE_W-1:0]  max_tone,
  input  logic        [mmtm_pkg::TONE_W-1:0]  smoothing_permille,
  output logic        [mmtm_pkg::TONE_W-1:0]  smoothed_tone
);
  import mmtm_pkg::*;

  logic signed [AXIS_W-1:0] ax [0:AXIS_COUNT-1];
  logic [2:0]               idx;
  logic [41:0]              prod;
  logic [41:0]              prod_next;
  logic [20:0]              mul_a;
  logic [20:0]              mul_b;
  logic [18:0]              acc;
  logic [18:0]              rad;
  logic [18:0]              res;
  logic [18:0]              bitm;
  logic [10:0]              mag_sum;
  logic [TONE_W-1:0]        clamped;
  logic [TONE_W-1:0]        weight_eff;
  logic [TONE_W-1:0]        tone_mem;
  logic [19:0]              blend;

  logic signed [AXIS_W-1:0] ax_sel;
  logic [AXIS_W:0]          ax_ext;
  logic [AXIS_W:0]          ax_mag;
  logic [8:0]               axis_q;
  logic [19:0]              trial;
  logic                     fits;
  logic [TONE_W-1:0]        raw;
  logic [TONE_W-1:0]        clamp_val;
  logic [TONE_W-1:0]        weight_sat;

  assign ax_sel = ax[idx];
  assign ax_ext = {ax_sel[AXIS_W-1], ax_sel};
  assign ax_mag = ax_sel[AXIS_W-1] ? ((AXIS_W+1)'(0) - ax_ext) : ax_ext;
  assign axis_q = prod[AXIS_SHIFT+8:AXIS_SHIFT];

  assign trial = {1'b0, res} + {1'b0, bitm};
  assign fits  = ({1'b0, rad} >= trial);

  assign raw = prod[TONE_SHIFT+TONE_W-1:TONE_SHIFT];

  always_comb begin
    if (raw < min_tone) begin
      clamp_val = min_tone;
    end else if (raw > max_tone) begin
      clamp_val = max_tone;
    end else begin
      clamp_val = raw;
    end
  end

  assign weight_sat = (smoothing_permille > WEIGHT_FULL) ? WEIGHT_FULL : smoothing_permille;

  // Operand select for the one shared multiplier.
  always_comb begin
    case (ctrl.op)
      OP_DIVAX: begin
        mul_a = 21'(ax_mag);
        mul_b = 21'(AXIS_RECIP);
      end
      OP_SQAX: begin
        mul_a = 21'(axis_q);
        mul_b = 21'(axis_q);
      end
      OP_SQSUM: begin
        mul_a = 21'(mag_sum);
        mul_b = 21'(mag_sum);
      end
      OP_DIVTONE: begin
        mul_a = prod[20:0];
        mul_b = TONE_RECIP;
      end
      OP_MULNEW: begin
        mul_a = 21'(clamped);
        mul_b = 21'(weight_eff);
      end
      OP_MULOLD: begin
        mul_a = 21'(tone_mem);
        mul_b = 21'(WEIGHT_FULL - weight_eff);
      end
      OP_DIVMIX: begin
        mul_a = 21'(blend);
        mul_b = MIX_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      case (ctrl.op) inside
        OP_LOAD: begin
          ax[0]   <= accel_x;
          ax[1]   <= accel_y;
          ax[2]   <= accel_z;
          ax[3]   <= gyro_x;
          ax[4]   <= gyro_y;
          ax[5]   <= gyro_z;
          idx     <= '0;
          acc     <= '0;
          mag_sum <= '0;
        end
        OP_DIVAX, OP_SQAX, OP_SQSUM, OP_DIVTONE, OP_MULNEW, OP_DIVMIX: begin
          prod <= prod_next;
        end
        OP_ACCUM: begin
          acc <= acc + {1'b0, prod[17:0]};
          idx <= idx + 3'd1;
        end
        OP_SQINIT: begin
          rad  <= acc;
          res  <= '0;
          bitm <= ROOT_TOP;
          acc  <= '0;
        end
        OP_SQSTEP: begin
          if (fits) begin
            rad <= rad - trial[18:0];
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
        end
        OP_MAGADD: begin
          mag_sum <= mag_sum + {1'b0, res[9:0]};
        end
        OP_CLAMP: begin
          clamped    <= clamp_val;
          weight_eff <= weight_sat;
        end
        OP_MULOLD: begin
          blend <= prod[19:0];
          prod  <= prod_next;
        end
        OP_MIXADD: begin
          blend <= blend + prod[19:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Stored tone doubles as the output register; it only moves when the output is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_mem <= TONE_RESET;
    end else if (ctrl.go && ctrl.op == OP_EMIT) begin
      tone_mem <= prod[MIX_SHIFT+TONE_W-1:MIX_SHIFT];
    end
  end

  assign stat.axis_more  = (idx != 3'(AXES_PER_GROUP - 1)) && (idx != 3'(AXIS_COUNT - 1));
  assign stat.root_more  = !bitm[0];
  assign stat.group_more = (idx != 3'(AXIS_COUNT));

  assign smoothed_tone = tone_mem;

endmodule

// ===== rtl/motion_magnitude_tone_mapper_unit.sv =====
// Top level of the motion magnitude tone mapper: config registers, sequencer and datapath.
// One item is in work at a time: a new one is taken only at the load step of the microcode
// program, which runs three steps per axis (divide by 100, square, accumulate), and each of
// the two square roots repeats the root step once for each of its ten result bits.
// The next item is taken while a finished result still waits on out_ready.
// Reset: min_tone 20, max_tone 300, smoothing_permille 200, stored tone 20, output empty.
module motion_magnitude_tone_mapper_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]    accel_x,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]    accel_y,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]    accel_z,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]    gyro_x,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]    gyro_y,
  input  logic signed [mmtm_pkg::AXIS_W-1:0]    gyro_z,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  output logic        [mmtm_pkg::TONE_W-1:0]    smoothed_tone,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [mmtm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic        [mmtm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic        [mmtm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                  pready
);
  import mmtm_pkg::*;

  typedef logic [CFG_ADDR_W-3:0] reg_idx_t;

  localparam reg_idx_t REG_MIN_TONE  = 2'd0;
  localparam reg_idx_t REG_MAX_TONE  = 2'd1;
  localparam reg_idx_t REG_SMOOTHING = 2'd2;

  logic [TONE_W-1:0] min_tone;
  logic [TONE_W-1:0] max_tone;
  logic [TONE_W-1:0] smoothing_permille;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  ctrl_t ctrl;
  stat_t stat;

  // Configuration port: zero wait states, word addresses.
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_tone           <= MIN_RESET;
      max_tone           <= MAX_RESET;
      smoothing_permille <= WEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIN_TONE:  min_tone           <= pwdata[TONE_W-1:0];
        REG_MAX_TONE:  max_tone           <= pwdata[TONE_W-1:0];
        REG_SMOOTHING: smoothing_permille <= pwdata[TONE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_TONE:  prdata = CFG_DATA_W'(min_tone);
      REG_MAX_TONE:  prdata = CFG_DATA_W'(max_tone);
      REG_SMOOTHING: prdata = CFG_DATA_W'(smoothing_permille);
      default:       prdata = '0;
    endcase
  end

  // Step counter and control ROM; waits at the load step for an item and at the
  // emit step while the previous result is still held.
  mmtm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl),
    .in_ready  (in_ready)
  );

  // Arithmetic: divide by 100, squares, roots, tone scaling, clamp and smoothing.
  mmtm_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .ctrl               (ctrl),
    .stat               (stat),
    .accel_x            (accel_x),
    .accel_y            (accel_y),
    .accel_z            (accel_z),
    .gyro_x             (gyro_x),
    .gyro_y             (gyro_y),
    .gyro_z             (gyro_z),
    .min_tone           (min_tone),
    .max_tone           (max_tone),
    .smoothing_permille (smoothing_permille),
    .smoothed_tone      (smoothed_tone)
  );

  // Output valid: set when the emit step fires, drop once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.go && ctrl.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/mmtm_checker.sv =====
// Port-level checks for the motion magnitude tone mapper, bound to the top level.
module mmtm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mmtm_pkg::TONE_W-1:0]  smoothed_tone
);
  import mmtm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(smoothed_tone))
    else $error("result changed or dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after accept");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

endmodule

bind motion_magnitude_tone_mapper_unit mmtm_checker u_mmtm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .smoothed_tone (smoothed_tone)
);
